// ----- rtl/c8ic_pkg.sv -----
package c8ic_pkg;

  localparam int unsigned RamBytesDef    = 4096;
  localparam int unsigned StackDepthDef  = 16;
  localparam int unsigned ScreenWidthDef = 64;
  localparam int unsigned ScreenHeightDef = 32;
  localparam logic [11:0] StartAddrDef   = 12'h200;
  localparam int unsigned FontBytes      = 80;

  typedef enum logic [2:0] {
    OP_EXEC   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_ROW    = 3'd3,
    OP_TICK   = 3'd4
  } item_op_t;

  // Result of one transaction, handed from the sequencer to the output stage.
  typedef struct packed {
    logic [63:0] read_data;
    logic [11:0] program_counter;
    logic        status;
    logic        screen_changed;
  } result_t;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] f;
    case (a)
      7'd0: f = 8'hF0;  7'd1: f = 8'h90;  7'd2: f = 8'h90;  7'd3: f = 8'h90;
      7'd4: f = 8'hF0;  7'd5: f = 8'h20;  7'd6: f = 8'h60;  7'd7: f = 8'h20;
      7'd8: f = 8'h20;  7'd9: f = 8'h70;  7'd10: f = 8'hF0; 7'd11: f = 8'h10;
      7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
      7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
      7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
      7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
      7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
      7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
      7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
      7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
      7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
      7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
      7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
      7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
      7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
      7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
      7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
      7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
      7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/c8ic_ram.sv -----
module c8ic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/c8ic_seq.sv -----
module c8ic_seq #(
  parameter int unsigned RAM_BYTES     = c8ic_pkg::RamBytesDef,
  parameter int unsigned STACK_DEPTH   = c8ic_pkg::StackDepthDef,
  parameter int unsigned SCREEN_HEIGHT = c8ic_pkg::ScreenHeightDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           op,
  input  logic [11:0]          addr,
  input  logic [7:0]           wdata,
  input  logic [7:0]           rnd,
  input  logic                 cfg_we,
  input  logic [11:0]          cfg_pc,
  output logic                 busy,
  output logic                 done,
  output c8ic_pkg::result_t    res
);
  import c8ic_pkg::*;

  localparam int unsigned AW  = $clog2(RAM_BYTES);
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned HW  = $clog2(SCREEN_HEIGHT);
  localparam int unsigned CLR = (RAM_BYTES > SCREEN_HEIGHT) ? RAM_BYTES : SCREEN_HEIGHT;
  localparam int unsigned CW  = $clog2(CLR) + 1;

  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_FETCH = 12'b000000000100,
    S_FET2  = 12'b000000001000,
    S_DEC   = 12'b000000010000,
    S_EXEC  = 12'b000000100000,
    S_RDM   = 12'b000001000000,
    S_SPR   = 12'b000010000000,
    S_SPRW  = 12'b000100000000,
    S_LDR   = 12'b001000000000,
    S_CLS   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // Memories.
  logic          m_we;
  logic [AW-1:0] m_wa, m_ra;
  logic [7:0]    m_wd, m_rd;
  logic          v_we;
  logic [3:0]    v_wa, v_ra;
  logic [7:0]    v_wd, v_rd;
  logic          k_we;
  logic [SW-1:0] k_wa, k_ra;
  logic [11:0]   k_wd, k_rd;
  logic          f_we;
  logic [HW-1:0] f_wa, f_ra;
  logic [63:0]   f_wd, f_rd;

  c8ic_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_mem (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  c8ic_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_fb (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  logic [11:0]   pc_r, pc_nxt, idx_r, idx_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic [7:0]    dt_r, dt_nxt;
  logic          halt_r, halt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   ins_r, ins_nxt;
  logic [7:0]    vx_r, vx_nxt, vy_r, vy_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [11:0]   addr_r, addr_nxt;
  logic [7:0]    rnd_r, rnd_nxt;
  logic [63:0]   rd_r, rd_nxt;
  logic          drew_r, drew_nxt, hit_r, hit_nxt;
  logic [7:0]    spr_r, spr_nxt;
  logic [1:0]    sub_r, sub_nxt;

  logic [3:0]  xi, yi, nn;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2, pc4;
  logic [8:0]  sum9;
  logic [7:0]  dig_h, dig_t, dig_o, dig_rem;
  logic [15:0] tens_prod;
  logic [5:0]  col;
  logic [127:0] spr_wide;
  logic [63:0]  spr_mask;

  assign xi  = ins_r[11:8];
  assign yi  = ins_r[7:4];
  assign nn  = ins_r[3:0];
  assign kk  = ins_r[7:0];
  assign nnn = ins_r[11:0];
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};
  assign dig_h = (vx_r >= 8'd200) ? 8'd2 : ((vx_r >= 8'd100) ? 8'd1 : 8'd0);
  assign dig_rem = vx_r - 8'(dig_h * 8'd100);
  // The tens digit of a value below 100 is its product with 205 shifted right by 11.
  assign tens_prod = {8'd0, dig_rem} * 16'd205;
  assign dig_t = {4'd0, tens_prod[14:11]};
  assign dig_o = dig_rem - 8'(dig_t * 8'd10);
  assign col = vx_r[5:0];
  // The sprite byte sits at the left edge, rotated right by the column with wrap.
  assign spr_wide = {spr_r, 56'd0, spr_r, 56'd0} >> col;
  assign spr_mask = spr_wide[127:64] | spr_wide[63:0];

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r; idx_nxt = idx_r; sp_nxt = sp_r; dt_nxt = dt_r;
    halt_nxt = halt_r; cnt_nxt = cnt_r; ins_nxt = ins_r;
    vx_nxt = vx_r; vy_nxt = vy_r; op_nxt = op_r; addr_nxt = addr_r;
    rnd_nxt = rnd_r; rd_nxt = rd_r; drew_nxt = drew_r;
    hit_nxt = hit_r; spr_nxt = spr_r; sub_nxt = sub_r;
    m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = pc_r[AW-1:0];
    v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
    k_we = 1'b0; k_wa = sp_r; k_wd = pc_r; k_ra = sp_r - SW'(1);
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = addr_r[HW-1:0];
    done = 1'b0;
    if (cfg_we) begin
      pc_nxt = cfg_pc;
    end
    unique case (state_r)
      S_INIT: begin
        // Loads the font and zeros RAM, registers, stack and screen.
        m_we = 1'b1; m_wa = cnt_r[AW-1:0];
        m_wd = (cnt_r < CW'(FontBytes)) ? font_byte(cnt_r[6:0]) : 8'h00;
        v_we = 1'b1; v_wa = cnt_r[3:0];
        k_we = 1'b1; k_wa = cnt_r[SW-1:0]; k_wd = '0;
        f_we = 1'b1; f_wa = cnt_r[HW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(CLR - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = op; addr_nxt = addr; rnd_nxt = rnd;
          rd_nxt = '0; drew_nxt = 1'b0;
          m_ra = addr[AW-1:0];
          f_ra = addr[HW-1:0];
          case (op)
            OP_EXEC: begin
              m_ra = pc_r[AW-1:0];
              state_nxt = halt_r ? S_DONE : S_FETCH;
            end
            OP_WRITE: begin
              m_we = 1'b1; m_wa = addr[AW-1:0]; m_wd = wdata;
              state_nxt = S_DONE;
            end
            OP_READ, OP_ROW: state_nxt = S_RDM;
            OP_TICK: begin
              if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RDM: begin
        rd_nxt = (op_r == OP_READ) ? {56'd0, m_rd} : f_rd;
        state_nxt = S_DONE;
      end
      S_FETCH: begin
        ins_nxt[15:8] = m_rd;
        m_ra = AW'(pc_r + 12'd1);
        state_nxt = S_FET2;
      end
      S_FET2: begin
        ins_nxt[7:0] = m_rd;
        v_ra = m_rd[7:4];
        // Vy read is issued via the register address taken from the low byte arriving here.
        state_nxt = S_DEC;
        sub_nxt = 2'd0;
      end
      S_DEC: begin
        // First cycle: Vy arrives; issue read of Vx.
        if (sub_r == 2'd0) begin
          vy_nxt = v_rd; v_ra = xi; sub_nxt = 2'd1;
        end else begin
          vx_nxt = v_rd; sub_nxt = 2'd0; state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        pc_nxt = pc2;
        unique case (ins_r[15:12])
          4'h0: begin
            if (ins_r == 16'h00E0) begin
              drew_nxt = 1'b1; cnt_nxt = '0; pc_nxt = pc_r; state_nxt = S_CLS;
            end else if (ins_r == 16'h00EE) begin
              // Stack read was issued in the previous cycle at sp-1.
              if (sub_r == 2'd0) begin
                sub_nxt = 2'd1; pc_nxt = pc_r; state_nxt = S_EXEC;
              end else begin
                sp_nxt = sp_r - SW'(1); pc_nxt = k_rd + 12'd2; sub_nxt = 2'd0;
              end
            end else begin
              halt_nxt = 1'b1; pc_nxt = pc_r;
            end
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            k_we = 1'b1; sp_nxt = sp_r + SW'(1); pc_nxt = nnn;
          end
          4'h3: if (vx_r == kk) pc_nxt = pc4;
          4'h4: if (vx_r != kk) pc_nxt = pc4;
          4'h5: if (vx_r == vy_r) pc_nxt = pc4;
          4'h6: begin v_we = 1'b1; v_wa = xi; v_wd = kk; end
          4'h7: begin v_we = 1'b1; v_wa = xi; v_wd = vx_r + kk; end
          4'h8: begin
            // For the flag-setting ops the flag goes to VF first; the result follows in the next cycle.
            case (nn)
              4'h0: begin v_we = 1'b1; v_wa = xi; v_wd = vy_r; end
              4'h1: begin v_we = 1'b1; v_wa = xi; v_wd = vx_r | vy_r; end
              4'h2: begin v_we = 1'b1; v_wa = xi; v_wd = vx_r & vy_r; end
              4'h3: begin v_we = 1'b1; v_wa = xi; v_wd = vx_r ^ vy_r; end
              4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                if (sub_r == 2'd0) begin
                  v_we = 1'b1; v_wa = 4'hF;
                  case (nn)
                    4'h4: v_wd = {7'd0, sum9[8]};
                    4'h5: v_wd = {7'd0, vx_r >= vy_r};
                    4'h6: v_wd = {7'd0, vx_r[0]};
                    4'h7: v_wd = {7'd0, vy_r >= vx_r};
                    default: v_wd = {7'd0, vx_r[7]};
                  endcase
                  sub_nxt = 2'd1; pc_nxt = pc_r; state_nxt = S_EXEC;
                end else begin
                  v_we = 1'b1; v_wa = xi; sub_nxt = 2'd0;
                  case (nn)
                    4'h4: v_wd = sum9[7:0];
                    4'h5: v_wd = vx_r - vy_r;
                    4'h6: v_wd = vx_r >> 1;
                    4'h7: v_wd = vy_r - vx_r;
                    default: v_wd = vx_r << 1;
                  endcase
                end
              end
              default: begin halt_nxt = 1'b1; pc_nxt = pc_r; end
            endcase
          end
          4'h9: if (vx_r != vy_r) pc_nxt = pc4;
          4'hA: idx_nxt = nnn;
          4'hC: begin v_we = 1'b1; v_wa = xi; v_wd = rnd_r & kk; end
          4'hD: begin
            drew_nxt = 1'b1; hit_nxt = 1'b0; cnt_nxt = '0;
            m_ra = idx_r[AW-1:0]; pc_nxt = pc_r;
            state_nxt = S_SPR;
          end
          4'hF: begin
            case (kk)
              8'h07: begin v_we = 1'b1; v_wa = xi; v_wd = dt_r; end
              8'h15: dt_nxt = vx_r;
              8'h29: idx_nxt = 12'(vx_r * 12'd5);
              8'h33: begin
                m_we = 1'b1;
                if (sub_r == 2'd0) begin
                  m_wa = idx_r[AW-1:0]; m_wd = dig_h;
                end else if (sub_r == 2'd1) begin
                  m_wa = AW'(idx_r + 12'd1); m_wd = dig_t;
                end else begin
                  m_wa = AW'(idx_r + 12'd2); m_wd = dig_o;
                end
                if (sub_r != 2'd2) begin
                  sub_nxt = sub_r + 2'd1; pc_nxt = pc_r; state_nxt = S_EXEC;
                end else begin
                  sub_nxt = 2'd0;
                end
              end
              8'h65: begin
                cnt_nxt = '0; m_ra = idx_r[AW-1:0]; pc_nxt = pc_r;
                state_nxt = S_LDR;
              end
              default: begin halt_nxt = 1'b1; pc_nxt = pc_r; end
            endcase
          end
          default: begin halt_nxt = 1'b1; pc_nxt = pc_r; end
        endcase
      end
      S_LDR: begin
        v_we = 1'b1; v_wa = cnt_r[3:0]; v_wd = m_rd;
        m_ra = AW'(idx_r + 12'(cnt_r) + 12'd1);
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r[3:0] == xi) begin
          pc_nxt = pc2; state_nxt = S_DONE;
        end
      end
      S_SPR: begin
        // Sprite byte arrives; issue the screen row read, or after the last row write the hit flag to VF.
        if (cnt_r[3:0] == nn) begin
          v_we = 1'b1; v_wa = 4'hF; v_wd = {7'd0, hit_r};
          pc_nxt = pc2; state_nxt = S_DONE;
        end else begin
          spr_nxt = m_rd;
          f_ra = HW'(vy_r + 8'(cnt_r));
          state_nxt = S_SPRW;
        end
      end
      S_SPRW: begin
        f_we = 1'b1; f_wa = HW'(vy_r + 8'(cnt_r)); f_wd = f_rd ^ spr_mask;
        if ((f_rd & spr_mask) != 64'd0) hit_nxt = 1'b1;
        m_ra = AW'(idx_r + 12'(cnt_r) + 12'd1);
        cnt_nxt = cnt_r + CW'(1);
        state_nxt = S_SPR;
      end
      S_CLS: begin
        f_we = 1'b1; f_wa = cnt_r[HW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SCREEN_HEIGHT - 1)) begin
          pc_nxt = pc2; state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done = 1'b1;
        if (halt_r) drew_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.read_data       = rd_r;
  assign res.program_counter = pc_r;
  assign res.status          = halt_r;
  assign res.screen_changed  = drew_r & ~halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      pc_r    <= StartAddrDef;
      idx_r   <= '0;
      sp_r    <= '0;
      dt_r    <= '0;
      halt_r  <= 1'b0;
      cnt_r   <= '0;
      sub_r   <= '0;
      drew_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      idx_r   <= idx_nxt;
      sp_r    <= sp_nxt;
      dt_r    <= dt_nxt;
      halt_r  <= halt_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
      drew_r  <= drew_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt; op_r <= op_nxt;
    addr_r <= addr_nxt; rnd_r <= rnd_nxt; rd_r <= rd_nxt;
    hit_r <= hit_nxt; spr_r <= spr_nxt;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE) else $error("done not followed by idle");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r && !cfg_we |=> halt_r) else $error("halt cleared");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |=> !done) else $error("result during init");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && !start |-> !m_we && !f_we) else $error("stray write");
`endif

endmodule

// ----- rtl/chip8_instruction_core.sv -----
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   opcode, address, write_data, random_byte
// out_     output     out_valid / out_stall read_data, program_counter, status, screen_changed
// cfg_     input      cfg_valid / cfg_ready data (start address)
// A transaction steps through the sequencer states: RAM writes and ticks go to done,
// RAM and row reads pass a read state, an instruction is fetched, decoded and executed;
// 8xy flag ops, 00EE and Fx33 repeat the execute state, a sprite reads and writes each row,
// Fx65 loads the registers and 00E0 clears the rows one by one, using registered memory reads.
// After reset a clearing pass loads the font and zeros the memories; no input is taken.
// The output register holds a result while out_stall is high; no input is taken meanwhile.
module chip8_instruction_core #(
  parameter int unsigned RAM_BYTES     = c8ic_pkg::RamBytesDef,
  parameter int unsigned STACK_DEPTH   = c8ic_pkg::StackDepthDef,
  parameter int unsigned SCREEN_WIDTH  = c8ic_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = c8ic_pkg::ScreenHeightDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [SCREEN_WIDTH-1:0] out_read_data,
  output logic [11:0] out_program_counter,
  output logic        out_status,
  output logic        out_screen_changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_start_address
);
  import c8ic_pkg::*;

  logic    busy, done, start;
  result_t res;
  logic    ov_r;
  result_t ob_r;

  assign in_stall  = busy | ov_r;
  assign start     = in_valid & ~in_stall;
  assign cfg_ready = ~busy;

  c8ic_seq #(.RAM_BYTES(RAM_BYTES), .STACK_DEPTH(STACK_DEPTH),
             .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_seq (
    .clk, .rst_n, .start, .op(in_opcode), .addr(in_address),
    .wdata(in_write_data), .rnd(in_random_byte),
    .cfg_we(cfg_valid & cfg_ready), .cfg_pc(cfg_start_address),
    .busy, .done, .res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (done) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) ob_r <= res;
  end

  assign out_valid           = ov_r;
  assign out_read_data       = ob_r.read_data[SCREEN_WIDTH-1:0];
  assign out_program_counter = ob_r.program_counter;
  assign out_status          = ob_r.status;
  assign out_screen_changed  = ob_r.screen_changed;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r) else $error("result dropped");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !ov_r || !out_stall) else $error("result overrun");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !ov_r) else $error("accept with pending result");
`endif

endmodule
